// ----- hdl/lcm_pkg.sv -----
`default_nettype none

package lcm_pkg;

  localparam int INDEX_BITS    = 24;
  localparam int FADE_BITS     = 24;
  localparam int SAMPLE_BITS   = 16;
  localparam int NARROW_BITS   = 8;
  localparam int GAIN_BITS     = 9;
  localparam int GAIN_FRAC     = 8;
  localparam int STEP_BITS     = 4;
  localparam int PROD_BITS     = SAMPLE_BITS + 1;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = FADE_BITS;

  localparam logic [STEP_BITS-1:0] ROUND_STEP = STEP_BITS'(GAIN_BITS);
  localparam int ROUND_BIAS = 128;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_LENGTH = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_MODE = 8'd1;

  localparam logic [FADE_BITS-1:0] FADE_LENGTH_RST = 24'd1024;
  localparam logic MODE_8BIT  = 1'b0;
  localparam logic MODE_16BIT = 1'b1;

  typedef struct packed {
    logic                        done;
    logic signed [PROD_BITS-1:0] prod;
  } lcm_scl_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/linear_crossfade_mixer.sv -----
// An accepted item runs a fade-in gain pass, a fade-out gain pass, a mix step and a send step;
// only then is a new item accepted. Both passes use the shared bit-serial gain divider
// (9 quotient bits plus a rounding step, run once per sample of the pair).
// A new item is accepted while the previous result waits in the output register.
// Reset (rst_n low, synchronous): fade_length = 1024, sample_mode = 1, index = 0.
`default_nettype none

module linear_crossfade_mixer
  import lcm_pkg::*;
(
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire signed [SAMPLE_BITS-1:0]   in_fade_in_sample,
  input  wire signed [SAMPLE_BITS-1:0]   in_fade_out_sample,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_mixed_sample,
  output logic                           out_fade_done,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire        [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire        [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int SUM_BITS = PROD_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FADE_IN  = 5'b00010,
    ST_FADE_OUT = 5'b00100,
    ST_MIX      = 5'b01000,
    ST_SEND     = 5'b10000
  } state_t;

  state_t                        state_r;
  logic [FADE_BITS-1:0]          fade_length_r;
  logic                          sample_mode_r;
  logic [INDEX_BITS-1:0]         sample_index_r;
  logic                          start_r;

  logic [FADE_BITS-1:0]          m_r;
  logic [FADE_BITS-1:0]          kc_r;
  logic [FADE_BITS-1:0]          xo_r;
  logic                          mode_r;
  logic                          done_r;
  logic signed [SAMPLE_BITS-1:0] si_r;
  logic signed [SAMPLE_BITS-1:0] so_r;
  logic signed [PROD_BITS-1:0]   a_r;
  logic signed [SUM_BITS-1:0]    sum_r;
  logic signed [SAMPLE_BITS-1:0] mix_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_mixed_sample_r;
  logic                          out_fade_done_r;

  logic                          in_acc;
  logic                          send_ok;
  logic [FADE_BITS-1:0]          m_eff;
  logic [FADE_BITS-1:0]          m_last;
  logic [FADE_BITS-1:0]          k_cur;
  logic                          at_end;
  logic [FADE_BITS-1:0]          k_clip;
  logic signed [SAMPLE_BITS-1:0] si_nxt;
  logic signed [SAMPLE_BITS-1:0] so_nxt;
  logic signed [SUM_BITS-1:0]    sum_adj;
  logic signed [SAMPLE_BITS-1:0] mix_nxt;

  logic [FADE_BITS-1:0]          scl_num;
  logic signed [SAMPLE_BITS-1:0] scl_sample;
  lcm_scl_rsp_t                  scl_rsp;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign send_ok   = !out_valid_r || out_ready;

  assign m_eff  = (fade_length_r == '0) ? FADE_BITS'(1) : fade_length_r;
  assign m_last = m_eff - 1'b1;
  assign k_cur  = FADE_BITS'(sample_index_r);
  assign at_end = (k_cur >= m_last);
  assign k_clip = (k_cur > m_last) ? m_last : k_cur;

  assign si_nxt = (sample_mode_r == MODE_16BIT) ? in_fade_in_sample :
                  {{(SAMPLE_BITS-NARROW_BITS){in_fade_in_sample[NARROW_BITS-1]}},
                   in_fade_in_sample[NARROW_BITS-1:0]};
  assign so_nxt = (sample_mode_r == MODE_16BIT) ? in_fade_out_sample :
                  {{(SAMPLE_BITS-NARROW_BITS){in_fade_out_sample[NARROW_BITS-1]}},
                   in_fade_out_sample[NARROW_BITS-1:0]};

  // halve toward zero: add one to negative sums before the shift
  assign sum_adj = sum_r + SUM_BITS'(sum_r[SUM_BITS-1]);
  assign mix_nxt = (mode_r == MODE_16BIT) ? sum_r[SAMPLE_BITS-1:0] :
                   {{(SAMPLE_BITS-NARROW_BITS){sum_adj[NARROW_BITS]}},
                    sum_adj[NARROW_BITS:1]};

  assign scl_num    = (state_r == ST_FADE_OUT) ? xo_r : kc_r;
  assign scl_sample = (state_r == ST_FADE_OUT) ? so_r : si_r;

  lcm_scaler u_scaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .gain_num (scl_num),
    .fade_len (m_r),
    .sample   (scl_sample),
    .rsp      (scl_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_length_r <= FADE_LENGTH_RST;
      sample_mode_r <= MODE_16BIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FADE_LENGTH: fade_length_r <= cfg_data[FADE_BITS-1:0];
        CFG_SAMPLE_MODE: sample_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sample_index_r <= '0;
      start_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r        <= ST_FADE_IN;
            start_r        <= 1'b1;
            sample_index_r <= at_end ? '0 : INDEX_BITS'(k_cur + 1'b1);
          end
        end
        ST_FADE_IN: begin
          if (scl_rsp.done) begin
            state_r <= ST_FADE_OUT;
            start_r <= 1'b1;
          end
        end
        ST_FADE_OUT: begin
          if (scl_rsp.done) begin
            state_r <= ST_MIX;
          end
        end
        ST_MIX: begin
          state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (send_ok) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (state_r == ST_SEND && send_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_r    <= m_eff;
      kc_r   <= k_clip;
      done_r <= at_end;
      mode_r <= sample_mode_r;
      si_r   <= si_nxt;
      so_r   <= so_nxt;
    end
    if (state_r == ST_FADE_IN) begin
      xo_r <= m_r - kc_r;
      if (scl_rsp.done) begin
        a_r <= scl_rsp.prod;
      end
    end
    if (state_r == ST_FADE_OUT && scl_rsp.done) begin
      sum_r <= SUM_BITS'(a_r) + SUM_BITS'(scl_rsp.prod);
    end
    if (state_r == ST_MIX) begin
      mix_r <= mix_nxt;
    end
    if (state_r == ST_SEND && send_ok) begin
      out_mixed_sample_r <= mix_r;
      out_fade_done_r    <= done_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_mixed_sample_r;
  assign out_fade_done    = out_fade_done_r;

  a_scl_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    scl_rsp.done |-> (state_r == ST_FADE_IN || state_r == ST_FADE_OUT))
    else $error("scaler finished outside a gain pass");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_FADE_IN && start_r))
    else $error("accepted item did not start the fade-in pass");

  a_index_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (done_r == (sample_index_r == '0)))
    else $error("index not cleared exactly on the last sample");

  a_out_from_send: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SEND))
    else $error("output loaded outside the send state");

endmodule

`default_nettype wire

// ----- hdl/lcm_scaler.sv -----
`default_nettype none

// gain = floor((512x + m) / 2m), one quotient bit per cycle, MSB first;
// each quotient bit folds the sample into a Horner accumulator.
module lcm_scaler
  import lcm_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire        [FADE_BITS-1:0]   gain_num,
  input  wire        [FADE_BITS-1:0]   fade_len,
  input  wire signed [SAMPLE_BITS-1:0] sample,
  output lcm_scl_rsp_t                 rsp
);

  localparam int REM_BITS = FADE_BITS + 1;
  localparam int ACC_BITS = SAMPLE_BITS + GAIN_BITS + 1;

  logic                          busy_r;
  logic                          done_r;
  logic [STEP_BITS-1:0]          step_r;
  logic [REM_BITS-1:0]           rem_r;
  logic [REM_BITS-1:0]           div_r;
  logic [GAIN_BITS-1:0]          nb_r;
  logic signed [SAMPLE_BITS-1:0] smp_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [PROD_BITS-1:0]   prod_r;

  logic [REM_BITS:0]             rem_sh;
  logic [REM_BITS+1:0]           diff;
  logic                          qbit;
  logic [REM_BITS-1:0]           rem_nxt;
  logic signed [ACC_BITS-1:0]    acc_nxt;
  logic signed [ACC_BITS-1:0]    rounded;
  logic [REM_BITS-1:0]           rem_init;

  assign rem_sh   = {rem_r, nb_r[GAIN_BITS-1]};
  assign diff     = {1'b0, rem_sh} - {2'b0, div_r};
  assign qbit     = ~diff[REM_BITS+1];
  assign rem_nxt  = qbit ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
  assign acc_nxt  = (acc_r <<< 1) + (qbit ? ACC_BITS'(smp_r) : ACC_BITS'(0));
  assign rounded  = acc_r + ACC_BITS'(ROUND_BIAS);
  // x <= m, so x + m/512 < 2m: the remainder starts below the divisor
  assign rem_init = REM_BITS'(gain_num) + REM_BITS'(fade_len[FADE_BITS-1:GAIN_BITS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == ROUND_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      nb_r  <= fade_len[GAIN_BITS-1:0];
      div_r <= {fade_len, 1'b0};
      smp_r <= sample;
      acc_r <= '0;
    end else if (busy_r && step_r != ROUND_STEP) begin
      rem_r <= rem_nxt;
      nb_r  <= nb_r << 1;
      acc_r <= acc_nxt;
    end else if (busy_r) begin
      prod_r <= rounded[PROD_BITS+GAIN_FRAC-1:GAIN_FRAC];
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule

`default_nettype wire
